/* src/double_add_sub_assert.svh */
// Assertion macros for the double adder top level.
`ifndef DOUBLE_ADD_SUB_ASSERT_SVH
`define DOUBLE_ADD_SUB_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DAS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* src/das_pkg.sv */
// Package with types and constants for the double adder.
`default_nettype none
package das_pkg;
    localparam int unsigned WordW = 64;
    localparam int unsigned FracW = 64;
    localparam int unsigned ExpW = 13;
    localparam logic [WordW-1:0] DefaultNanReset = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] ExpMax = 11'h7FF;
    localparam logic [FracW-1:0] OneBit = 64'h1000_0000_0000_0000;
    localparam logic [FracW-1:0] TwoBit = 64'h2000_0000_0000_0000;
    localparam logic [51:0] QuietBit = 52'h8_0000_0000_0000;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_NUM  = 2'd1,
        KIND_INF  = 2'd2,
        KIND_NAN  = 2'd3
    } kind_t;

    // Signed exponent wide enough for all intermediate values.
    typedef logic signed [ExpW-1:0] exp_t;

    // Unpacked operand.
    typedef struct packed {
        kind_t            kind;
        logic             sign;
        exp_t             ex;
        logic [FracW-1:0] fr;
    } parts_t;

    // Leading zero count of a 64-bit word.
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

/* src/das_pack.sv */
// Final stage: rounding, overflow, underflow and packing of the result.
`default_nettype none
module das_pack
    import das_pkg::*;
(
    input  wire parts_t           r,
    output logic [WordW-1:0]      word
);
    logic [FracW-1:0] fr;
    logic [FracW-1:0] fr_sh;
    logic [10:0]      e;
    exp_t             sh;

    always_comb begin
        fr = r.fr;
        e = '0;
        sh = exp_t'(-1022) - r.ex;
        fr_sh = '0;
        case (r.kind)
            KIND_NAN: begin
                e = ExpMax;
                fr = r.fr | {12'd0, QuietBit};
            end
            KIND_INF: begin
                e = ExpMax;
                fr = '0;
            end
            default: begin
                if (r.kind == KIND_ZERO || r.fr == '0) begin
                    fr = '0;
                end else if (r.ex < exp_t'(-1022)) begin
                    fr_sh = (sh > exp_t'(56)) ? '0 : (r.fr >> sh[5:0]);
                    fr = fr_sh >> 8;
                end else if (r.ex > exp_t'(1023)) begin
                    e = ExpMax;
                    fr = '0;
                end else begin
                    e = 11'(r.ex + exp_t'(1023));
                    if (fr[7:0] == 8'h80) begin
                        if (fr[8]) fr = fr + 64'h80;
                    end else begin
                        fr = fr + 64'h7F;
                    end
                    if (fr >= TwoBit) begin
                        fr = fr >> 1;
                        e = e + 11'd1;
                    end
                    fr = fr >> 8;
                end
            end
        endcase
        word = {r.sign, e, fr[51:0]};
    end
endmodule
`default_nettype wire

/* src/double_add_sub.sv */
// Top level of the pipelined IEEE-754 double adder and subtractor.
//
// Channel   Direction  Ports                               Meaning
// input     in         s_valid s_ready s_op s_a_bits s_b_bits  one operation per item
// result    out        m_valid m_ready m_result_bits       one packed double per item
// config    in         cfg_we cfg_wdata                    default NaN pattern
//
// Each item passes four register stages: unpack and classify, align with a
// sticky bit, add or subtract with normalisation, then round and pack.
// One item can enter every cycle unless a stall at m_ready holds the pipeline.
// Reset is synchronous and active low; it clears the valid bits and sets
// the default NaN register. A stall at m_ready freezes the whole pipeline,
// and s_ready falls only while the final stage holds an item not taken.
`default_nettype none
module double_add_sub
    import das_pkg::*;
#(
    parameter logic [WordW-1:0] DEFAULT_NAN = DefaultNanReset
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire               s_op,
    input  wire [WordW-1:0]   s_a_bits,
    input  wire [WordW-1:0]   s_b_bits,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [WordW-1:0]  m_result_bits,
    input  wire               cfg_we,
    input  wire [WordW-1:0]   cfg_wdata
);
`include "double_add_sub_assert.svh"

    // The pipeline advances whenever the output stage is free or emptying.
    logic adv;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    logic [WordW-1:0] nan_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) nan_reg <= DEFAULT_NAN;
        else if (cfg_we) nan_reg <= cfg_wdata;
    end

    // Stage 1: unpack both operands and resolve the special cases.
    function automatic parts_t unpack(input logic [63:0] w);
        parts_t p;
        p.sign = w[63];
        p.ex = '0;
        p.fr = '0;
        if (w[62:52] == 11'd0) begin
            p.kind = KIND_ZERO;
        end else if (w[62:52] == ExpMax) begin
            if (w[51:0] == '0) p.kind = KIND_INF;
            else begin
                p.kind = KIND_NAN;
                p.fr = {12'd0, w[51:0]};
            end
        end else begin
            p.kind = KIND_NUM;
            p.ex = exp_t'({2'b00, w[62:52]}) - exp_t'(1023);
            p.fr = {w[51:0], 8'd0} | OneBit;
        end
        return p;
    endfunction

    parts_t ua, ub;
    always_comb begin
        ua = unpack(s_a_bits);
        ub = unpack(s_b_bits);
        ub.sign = ub.sign ^ s_op;
    end

    // A special case is settled here and carried as a finished part set.
    logic   v1_reg, sp1_reg, spn1_reg;
    parts_t a1_reg, b1_reg, sp1p_reg;
    logic   sp1_next, spn1_next;
    parts_t sp1p_next;
    always_comb begin
        sp1_next = 1'b1;
        spn1_next = 1'b0;
        sp1p_next = ua;
        if (ua.kind == KIND_NAN) sp1p_next = ua;
        else if (ub.kind == KIND_NAN) sp1p_next = ub;
        else if (ua.kind == KIND_INF) begin
            if (ub.kind == KIND_INF && ua.sign != ub.sign) spn1_next = 1'b1;
        end else if (ub.kind == KIND_INF) sp1p_next = ub;
        else if (ub.kind == KIND_ZERO) begin
            if (ua.kind == KIND_ZERO) sp1p_next.sign = ua.sign & ub.sign;
        end else if (ua.kind == KIND_ZERO) sp1p_next = ub;
        else sp1_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_valid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg <= ua;
            b1_reg <= ub;
            sp1_reg <= sp1_next;
            spn1_reg <= spn1_next;
            sp1p_reg <= sp1p_next;
        end
    end

    // Stage 2: align the smaller operand with a sticky bit.
    function automatic logic [63:0] shift_sticky(input logic [63:0] f, input exp_t k);
        logic [63:0] lo;
        if (k <= 0) return f;
        if (k >= exp_t'(64)) return '0;
        lo = f & ((64'd1 << k[5:0]) - 64'd1);
        return (f >> k[5:0]) | {63'd0, lo != '0};
    endfunction

    logic        v2_reg, sp2_reg, spn2_reg, sa2_reg, sb2_reg;
    parts_t      sp2p_reg;
    exp_t        e2_reg;
    logic [63:0] af2_reg, bf2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sp2_reg <= sp1_reg;
            spn2_reg <= spn1_reg;
            sp2p_reg <= sp1p_reg;
            sa2_reg <= a1_reg.sign;
            sb2_reg <= b1_reg.sign;
            if (a1_reg.ex > b1_reg.ex) begin
                e2_reg <= a1_reg.ex;
                af2_reg <= a1_reg.fr;
                bf2_reg <= shift_sticky(b1_reg.fr, a1_reg.ex - b1_reg.ex);
            end else begin
                e2_reg <= b1_reg.ex;
                bf2_reg <= b1_reg.fr;
                af2_reg <= shift_sticky(a1_reg.fr, b1_reg.ex - a1_reg.ex);
            end
        end
    end

    // Stage 3: add or subtract, then normalise.
    parts_t r3;
    logic [63:0] d3, m3;
    logic [6:0]  lz3;
    always_comb begin
        r3.kind = KIND_NUM;
        r3.ex = e2_reg;
        d3 = sa2_reg ? (bf2_reg - af2_reg) : (af2_reg - bf2_reg);
        m3 = d3[63] ? (64'd0 - d3) : d3;
        lz3 = lzc64(m3);
        if (sa2_reg != sb2_reg) begin
            r3.sign = d3[63];
            r3.fr = m3;
            if (m3 != '0 && m3 < OneBit) begin
                r3.fr = m3 << (lz3 - 7'd3);
                r3.ex = e2_reg - exp_t'(lz3 - 7'd3);
            end
        end else begin
            r3.sign = sa2_reg;
            r3.fr = af2_reg + bf2_reg;
        end
        if (r3.fr >= TwoBit) begin
            r3.fr = {1'b0, r3.fr[63:1]} | {63'd0, r3.fr[0]};
            r3.ex = r3.ex + exp_t'(1);
        end
        if (sp2_reg) r3 = sp2p_reg;
    end

    logic   v3_reg, spn3_reg;
    parts_t r3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            r3_reg <= r3;
            spn3_reg <= spn2_reg;
        end
    end

    // Stage 4: round and pack into the output register.
    logic [WordW-1:0] packed_word;
    das_pack u_pack (.r(r3_reg), .word(packed_word));

    logic             mv_reg;
    logic [WordW-1:0] res_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (adv) mv_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) res_reg <= spn3_reg ? nan_reg : packed_word;
    end
    assign m_valid = mv_reg;
    assign m_result_bits = res_reg;

    `DAS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_bits))
    `DAS_ASSERT_IMP(a_ready, aclk, aresetn, !s_ready, m_valid)
    `DAS_ASSERT_NEXT(a_flow, aclk, aresetn, v3_reg && adv, m_valid)
endmodule
`default_nettype wire
